// File: rtl/lav_pkg.sv
// ----------------------------------------------------------------------------
// lav_pkg: shared constants of the look-at view matrix unit
// Field widths, stream widths and fixed-point constants.
// ----------------------------------------------------------------------------
package lav_pkg;

  localparam int unsigned PosW   = 32;
  localparam int unsigned DirW   = 16;
  localparam int unsigned FracDir = 14;

  // Input item: pos x/y/z, look x/y/z, up x/y/z.
  localparam int unsigned InW  = 3 * PosW + 6 * DirW;
  // Result item: right x/y/z, true_up x/y/z, fwd x/y/z, trans 0/1/2.
  localparam int unsigned OutW = 9 * DirW + 3 * PosW;

  // Offsets of the result fields inside the output tdata.
  localparam int unsigned OffRight  = 0;
  localparam int unsigned OffTrueUp = 3 * DirW;
  localparam int unsigned OffFwd    = 6 * DirW;
  localparam int unsigned OffTrans  = 9 * DirW;

  localparam logic signed [DirW-1:0] DirOne    = 16'sd16384;
  localparam logic signed [DirW-1:0] DirNegOne = -16'sd16384;

endpackage

// File: rtl/look_at_view_matrix_unit.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix_unit: fixed-point look-at view matrix
// Structure: a 7 stage pipeline (up x look products, right clamp, look x right
// products, true-up clamp, row by position products, dot sum, negate and
// saturate); each item passes through every stage in that order.
// Throughput: one item per cycle; each stage stalls only when it is full and
// the stage after it cannot take its item.
// Reset: asynchronous, active low, clears all stage valid bits.
// ----------------------------------------------------------------------------
module look_at_view_matrix_unit
  import lav_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  // Fields from bit 0 up: pos_x, pos_y, pos_z (32 each),
  // look_x, look_y, look_z, up_x, up_y, up_z (16 each).
  input  logic [InW-1:0]  s_axis_tdata_i,
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  // Fields from bit 0 up: right_x, right_y, right_z, true_up_x, true_up_y,
  // true_up_z, fwd_x, fwd_y, fwd_z (16 each), trans_0, trans_1, trans_2 (32 each).
  output logic [OutW-1:0] m_axis_tdata_o
);

  localparam int unsigned NStages = 7;
  localparam int unsigned PrdW    = 2 * DirW;
  localparam int unsigned DifW    = PrdW + 1;
  localparam int unsigned ShW     = DifW - FracDir;
  localparam int unsigned TPrdW   = DirW + PosW;
  localparam int unsigned SumW    = TPrdW + 2;
  localparam int unsigned DotW    = SumW - FracDir;
  localparam int unsigned NegW    = DotW + 1;

  // Cross product component: floor shift of the exact difference, then clamp.
  function automatic logic signed [DirW-1:0] cross_comp(
    input logic signed [PrdW-1:0] a,
    input logic signed [PrdW-1:0] b
  );
    logic signed [DifW-1:0] dif;
    logic signed [ShW-1:0]  sh;
    dif = DifW'(a) - DifW'(b);
    sh  = dif[DifW-1:FracDir];
    if (sh > ShW'(DirOne)) begin
      cross_comp = DirOne;
    end else if (sh < ShW'(DirNegOne)) begin
      cross_comp = DirNegOne;
    end else begin
      cross_comp = sh[DirW-1:0];
    end
  endfunction

  // Translation: floor shift of the dot sum, negate, saturate to 32 bits.
  function automatic logic signed [PosW-1:0] sat_trans(input logic signed [SumW-1:0] s);
    logic signed [DotW-1:0] dot;
    logic signed [NegW-1:0] neg;
    logic signed [NegW-1:0] hi;
    logic signed [NegW-1:0] lo;
    dot = s[SumW-1:FracDir];
    neg = -NegW'(dot);
    hi  = NegW'({1'b0, {(PosW-1){1'b1}}});
    lo  = -NegW'({1'b1, {(PosW-1){1'b0}}});
    if (neg > hi) begin
      sat_trans = {1'b0, {(PosW-1){1'b1}}};
    end else if (neg < lo) begin
      sat_trans = {1'b1, {(PosW-1){1'b0}}};
    end else begin
      sat_trans = neg[PosW-1:0];
    end
  endfunction

  logic [NStages-1:0] vld_q;
  logic [NStages:0]   rdy;

  always_comb begin
    rdy[NStages] = m_axis_tready_i;
    for (int k = NStages - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign s_axis_tready_o = rdy[0];
  assign m_axis_tvalid_o = vld_q[NStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < NStages; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Input unpacking.
  logic signed [PosW-1:0] in_p [3];
  logic signed [DirW-1:0] in_n [3];
  logic signed [DirW-1:0] in_w [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_p[i] = s_axis_tdata_i[PosW*i +: PosW];
      in_n[i] = s_axis_tdata_i[3*PosW + DirW*i +: DirW];
      in_w[i] = s_axis_tdata_i[3*PosW + 3*DirW + DirW*i +: DirW];
    end
  end

  // Stage payload registers; each stage carries what later stages still need.
  logic signed [PrdW-1:0]  s0_prd_q [6];
  logic signed [PosW-1:0]  s0_p_q [3];
  logic signed [DirW-1:0]  s0_n_q [3];

  logic signed [DirW-1:0]  s1_u_q [3];
  logic signed [PosW-1:0]  s1_p_q [3];
  logic signed [DirW-1:0]  s1_n_q [3];

  logic signed [PrdW-1:0]  s2_prd_q [6];
  logic signed [DirW-1:0]  s2_u_q [3];
  logic signed [PosW-1:0]  s2_p_q [3];
  logic signed [DirW-1:0]  s2_n_q [3];

  logic signed [DirW-1:0]  s3_v_q [3];
  logic signed [DirW-1:0]  s3_u_q [3];
  logic signed [PosW-1:0]  s3_p_q [3];
  logic signed [DirW-1:0]  s3_n_q [3];

  logic signed [TPrdW-1:0] s4_tp_q [3][3];
  logic signed [DirW-1:0]  s4_u_q [3];
  logic signed [DirW-1:0]  s4_v_q [3];
  logic signed [DirW-1:0]  s4_n_q [3];

  logic signed [SumW-1:0]  s5_sum_q [3];
  logic signed [DirW-1:0]  s5_u_q [3];
  logic signed [DirW-1:0]  s5_v_q [3];
  logic signed [DirW-1:0]  s5_n_q [3];

  logic signed [PosW-1:0]  s6_t_q [3];
  logic signed [DirW-1:0]  s6_u_q [3];
  logic signed [DirW-1:0]  s6_v_q [3];
  logic signed [DirW-1:0]  s6_n_q [3];

  // Stage 0: up x look partial products.
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s0_prd_q[0] <= in_w[1] * in_n[2];
      s0_prd_q[1] <= in_w[2] * in_n[1];
      s0_prd_q[2] <= in_w[2] * in_n[0];
      s0_prd_q[3] <= in_w[0] * in_n[2];
      s0_prd_q[4] <= in_w[0] * in_n[1];
      s0_prd_q[5] <= in_w[1] * in_n[0];
      s0_p_q      <= in_p;
      s0_n_q      <= in_n;
    end
  end

  // Stage 1: right axis.
  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      for (int i = 0; i < 3; i++) begin
        s1_u_q[i] <= cross_comp(s0_prd_q[2*i], s0_prd_q[2*i+1]);
      end
      s1_p_q <= s0_p_q;
      s1_n_q <= s0_n_q;
    end
  end

  // Stage 2: look x right partial products.
  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      s2_prd_q[0] <= s1_n_q[1] * s1_u_q[2];
      s2_prd_q[1] <= s1_n_q[2] * s1_u_q[1];
      s2_prd_q[2] <= s1_n_q[2] * s1_u_q[0];
      s2_prd_q[3] <= s1_n_q[0] * s1_u_q[2];
      s2_prd_q[4] <= s1_n_q[0] * s1_u_q[1];
      s2_prd_q[5] <= s1_n_q[1] * s1_u_q[0];
      s2_u_q      <= s1_u_q;
      s2_p_q      <= s1_p_q;
      s2_n_q      <= s1_n_q;
    end
  end

  // Stage 3: true up axis.
  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      for (int i = 0; i < 3; i++) begin
        s3_v_q[i] <= cross_comp(s2_prd_q[2*i], s2_prd_q[2*i+1]);
      end
      s3_u_q <= s2_u_q;
      s3_p_q <= s2_p_q;
      s3_n_q <= s2_n_q;
    end
  end

  // Stage 4: row by position products, one 16 x 32 multiply each.
  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      for (int i = 0; i < 3; i++) begin
        s4_tp_q[0][i] <= s3_u_q[i] * s3_p_q[i];
        s4_tp_q[1][i] <= s3_v_q[i] * s3_p_q[i];
        s4_tp_q[2][i] <= s3_n_q[i] * s3_p_q[i];
      end
      s4_u_q <= s3_u_q;
      s4_v_q <= s3_v_q;
      s4_n_q <= s3_n_q;
    end
  end

  // Stage 5: exact dot sums.
  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      for (int r = 0; r < 3; r++) begin
        s5_sum_q[r] <= SumW'(s4_tp_q[r][0]) + SumW'(s4_tp_q[r][1]) + SumW'(s4_tp_q[r][2]);
      end
      s5_u_q <= s4_u_q;
      s5_v_q <= s4_v_q;
      s5_n_q <= s4_n_q;
    end
  end

  // Stage 6: negate and saturate the translations into the output register.
  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      for (int r = 0; r < 3; r++) begin
        s6_t_q[r] <= sat_trans(s5_sum_q[r]);
      end
      s6_u_q <= s5_u_q;
      s6_v_q <= s5_v_q;
      s6_n_q <= s5_n_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_axis_tdata_o[OffRight  + DirW*i +: DirW] = s6_u_q[i];
      m_axis_tdata_o[OffTrueUp + DirW*i +: DirW] = s6_v_q[i];
      m_axis_tdata_o[OffFwd    + DirW*i +: DirW] = s6_n_q[i];
      m_axis_tdata_o[OffTrans  + PosW*i +: PosW] = s6_t_q[i];
    end
  end

endmodule

// File: rtl/lav_checker.sv
// ----------------------------------------------------------------------------
// lav_checker: port-level checks of the look-at view matrix unit
// Watches the stream ports and flags handshake and range violations.
// ----------------------------------------------------------------------------
module lav_checker
  import lav_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tready_o,
  input logic            m_axis_tvalid_o,
  input logic            m_axis_tready_i,
  input logic [OutW-1:0] m_axis_tdata_o
);

  logic signed [DirW-1:0] right_x;
  logic signed [DirW-1:0] true_up_z;

  assign right_x   = m_axis_tdata_o[OffRight +: DirW];
  assign true_up_z = m_axis_tdata_o[OffTrueUp + 2*DirW +: DirW];

  // A stalled result item stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result item dropped while stalled");

  // A stalled result item keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result payload changed while stalled");

  // No result can appear in the cycle right after reset is released.
  assert property (@(posedge clk_i)
    rst_ni && !$past(rst_ni) |-> !m_axis_tvalid_o)
    else $error("result valid right after reset");

  // A receiver that takes items never holds back the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("input blocked while the receiver is ready");

  // The right x and true up z components are clamped to the unit range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (right_x <= DirOne) && (right_x >= DirNegOne)
                        && (true_up_z <= DirOne) && (true_up_z >= DirNegOne))
    else $error("cross product component outside unit range");

endmodule

bind look_at_view_matrix_unit lav_checker u_lav_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
